FILE: hw/rtl/mxfp4_block_dequant_to_bf16_core_assert.svh
// Assertion macros for the checker module of the MXFP4 dequantizer.
// Depends on nothing; included by the checker module.
`ifndef MXFP4_BLOCK_DEQUANT_TO_BF16_CORE_ASSERT_SVH
`define MXFP4_BLOCK_DEQUANT_TO_BF16_CORE_ASSERT_SVH

// Implication checked every clock edge, disabled in reset.
`define MX_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent, disabled in reset.
`define MX_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/mxdq_pkg.sv
// Package for the MXFP4 to BF16 dequantizer: BF16 constants and the E2M1 tables.
// Used by mxdq_conv and the testbench; depends on nothing.
`timescale 1ns / 1ps
package mxdq_pkg;
  localparam logic [7:0] SCALE_MAX = 8'd255;
  localparam logic [15:0] BF16_SIGN = 16'h8000;
  localparam logic [15:0] BF16_INF = 16'h7F80;

  function automatic logic [1:0] code_exp_ofs(input logic [2:0] mag);
    logic [1:0] r;
    case (mag)
      3'd4, 3'd5: r = 2'd1;
      3'd6, 3'd7: r = 2'd2;
      default: r = 2'd0;
    endcase
    return r;
  endfunction

  function automatic logic code_half(input logic [2:0] mag);
    return (mag == 3'd3) || (mag == 3'd5) || (mag == 3'd7);
  endfunction
endpackage

FILE: hw/rtl/mxdq_conv.sv
// Converts one E2M1 nibble and an E8M0 scale to a BF16 bit pattern.
// Depends on mxdq_pkg.
`timescale 1ns / 1ps
module mxdq_conv (
  input  logic [3:0]  code,
  input  logic [7:0]  scale,
  output logic [15:0] value
);
  logic [2:0] mag;
  logic [9:0] e;
  logic [15:0] sgn;

  assign mag = code[2:0];
  assign sgn = code[3] ? mxdq_pkg::BF16_SIGN : 16'h0000;

  always_comb begin
    if (mag == 3'd1) begin
      e = {2'b00, scale} - 10'd1;
    end else begin
      e = {2'b00, scale} + {8'd0, mxdq_pkg::code_exp_ofs(mag)};
    end
    if (mag == 3'd0) begin
      value = 16'h0000;
    end else if (scale == 8'd0 || scale == mxdq_pkg::SCALE_MAX) begin
      value = sgn;
    end else if (e >= 10'd255 && !e[9]) begin
      value = sgn | mxdq_pkg::BF16_INF;
    end else if (e == 10'd0 || e[9]) begin
      value = sgn;
    end else begin
      value = sgn | {1'b0, e[7:0], mxdq_pkg::code_half(mag), 6'd0};
    end
  end
endmodule

FILE: hw/rtl/mxfp4_block_dequant_to_bf16_core.sv
// MXFP4 block dequantizer, byte stream in, BF16 pairs out, one byte a cycle
// unless stalled. A stalled output holds one word in its register while the input
// keeps flowing whenever that register is empty or being taken. The word of a data
// byte is on the output in the next cycle. Scale bytes give no word.
// Depends on mxdq_conv.
`timescale 1ns / 1ps
module mxfp4_block_dequant_to_bf16_core #(
  parameter int ELEMENTS_PER_BLOCK = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // stream_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // value_low [15:0], value_high [31:16]
  output logic        m_axis_tlast    // block_end
);
  localparam int DATA_BYTES = (ELEMENTS_PER_BLOCK + 1) / 2;
  localparam int POS_W = $clog2(DATA_BYTES + 1);

  logic [POS_W-1:0] byte_position;
  logic [7:0] block_scale;
  logic [15:0] lo, hi;
  logic acc, last;

  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign acc = s_axis_tvalid && s_axis_tready;
  assign last = byte_position >= POS_W'(DATA_BYTES);

  mxdq_conv u_lo (.code(s_axis_tdata[3:0]), .scale(block_scale), .value(lo));
  mxdq_conv u_hi (.code(s_axis_tdata[7:4]), .scale(block_scale), .value(hi));

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      block_scale <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      if (acc) begin
        if (byte_position == '0) begin
          block_scale <= s_axis_tdata;
          byte_position <= POS_W'(1);
        end else begin
          m_axis_tvalid <= 1'b1;
          m_axis_tdata <= {hi, lo};
          m_axis_tlast <= last;
          byte_position <= last ? '0 : byte_position + POS_W'(1);
        end
      end
    end
  end
endmodule

FILE: hw/rtl/mxdq_checker.sv
// Port-level checker for the MXFP4 dequantizer, bound to the top level.
// Depends on the assertion macro header.
`timescale 1ns / 1ps
`include "mxfp4_block_dequant_to_bf16_core_assert.svh"
module mxdq_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [7:0]  s_axis_tdata,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic        m_axis_tlast
);
  `MX_ASSERT_IMPL(a_ready, !m_axis_tvalid, s_axis_tready, "ready low with empty output")
  `MX_ASSERT_NEXT(a_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "stalled word changed")
  `MX_ASSERT_NEXT(a_noin, !(s_axis_tvalid && s_axis_tready) && !(m_axis_tvalid && !m_axis_tready), !m_axis_tvalid, "word without input")
  `MX_ASSERT_IMPL(a_zero, m_axis_tvalid && m_axis_tdata[14:0] == 15'd0, m_axis_tdata[15] == 1'b0 || m_axis_tdata[15:0] == 16'h8000, "bad zero")
endmodule

bind mxfp4_block_dequant_to_bf16_core mxdq_checker u_chk (.*);

FILE: tb/tb.sv
// Testbench for the MXFP4 block dequantizer: drives 17-byte blocks and checks each BF16 word.
// Holds its own predictor of the block; depends on mxdq_pkg and the core.
`timescale 1ns / 1ps
module tb;
  localparam int DATA_BYTES = 16;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int N_RANDOM = 1400;

  typedef struct packed {
    logic [15:0] lo;
    logic [15:0] hi;
    logic        last;
  } pair_t;

  typedef struct {
    logic [7:0] b;
    logic       known;
    pair_t      want;
  } row_t;

  logic clk = 0;
  logic rst = 1;
  logic s_axis_tvalid = 0;
  logic s_axis_tready;
  logic [7:0] s_axis_tdata = 0;
  logic m_axis_tvalid;
  logic m_axis_tready = 0;
  logic [31:0] m_axis_tdata;
  logic m_axis_tlast;

  mxfp4_block_dequant_to_bf16_core dut (.*);

  always #5 clk = ~clk;

  int unsigned pos_q = 0;
  logic [7:0] scale_q = 0;
  pair_t pending_pairs[$];
  pair_t typed_pairs[$];
  logic typed_known[$];
  int errors = 0;
  int idle_cycles = 0;
  bit quiet = 0;
  bit hold_off = 0;
  logic cur_known = 0;
  pair_t cur_want = '0;
  int r_total = 0;
  row_t rows[$];

  function automatic logic [15:0] fp4_value(logic [3:0] code, logic [7:0] scale);
    logic [15:0] sgn;
    int e;
    int ofs;
    sgn = code[3] ? mxdq_pkg::BF16_SIGN : 16'h0000;
    if (code[2:0] == 3'd0) return 16'h0000;
    if (scale == 8'd0 || scale == mxdq_pkg::SCALE_MAX) return sgn;
    case (code[2:0])
      3'd1: ofs = -1;
      3'd2, 3'd3: ofs = 0;
      3'd4, 3'd5: ofs = 1;
      default: ofs = 2;
    endcase
    e = int'(scale) + ofs;
    if (e >= 255) return sgn | mxdq_pkg::BF16_INF;
    if (e <= 0) return sgn;
    return sgn | 16'(e << 7) | ((code[0] && code[2:0] != 3'd1) ? 16'h0040 : 16'h0000);
  endfunction

  // Advances the predictor by one accepted byte.
  task automatic predict_byte(logic [7:0] b, logic known, pair_t want);
    pair_t p;
    if (pos_q == 0) begin
      scale_q = b;
      pos_q = 1;
    end else begin
      p.lo = fp4_value(b[3:0], scale_q);
      p.hi = fp4_value(b[7:4], scale_q);
      p.last = (pos_q >= DATA_BYTES);
      pos_q = p.last ? 0 : pos_q + 1;
      pending_pairs.push_back(p);
      typed_pairs.push_back(want);
      typed_known.push_back(known);
    end
  endtask

  always @(posedge clk) begin
    pair_t w;
    pair_t t;
    logic k;
    if (!rst && s_axis_tvalid && s_axis_tready)
      predict_byte(s_axis_tdata, cur_known, cur_want);
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_pairs.size() == 0) begin
        $error("unexpected word %h last %b", m_axis_tdata, m_axis_tlast);
        errors++;
      end else begin
        w = pending_pairs.pop_front();
        t = typed_pairs.pop_front();
        k = typed_known.pop_front();
        if (k) w = t;
        if (m_axis_tdata[15:0] !== w.lo) begin
          $error("value_low expected %h actual %h", w.lo, m_axis_tdata[15:0]);
          errors++;
        end
        if (m_axis_tdata[31:16] !== w.hi) begin
          $error("value_high expected %h actual %h", w.hi, m_axis_tdata[31:16]);
          errors++;
        end
        if (m_axis_tlast !== w.last) begin
          $error("block_end expected %b actual %b", w.last, m_axis_tlast);
          errors++;
        end
      end
    end
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  // Receiver: random stalls, a quiet stretch, and one long hold-off.
  always @(negedge clk) begin
    if (rst) m_axis_tready <= 0;
    else if (hold_off) m_axis_tready <= 0;
    else m_axis_tready <= quiet ? 1'b1 : ($urandom_range(0, 99) >= 22);
  end

  task automatic send_byte(logic [7:0] b, logic known, pair_t want);
    while (!quiet && $urandom_range(0, 99) < 22) begin
      s_axis_tvalid <= 0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata <= b;
    cur_known <= known;
    cur_want <= want;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_block(logic [7:0] scale);
    send_byte(scale, 0, '0);
    for (int i = 0; i < DATA_BYTES; i++)
      send_byte(8'($urandom), 0, '0);
  endtask

  task automatic add_row(logic [7:0] b, logic known, logic [15:0] lo, logic [15:0] hi,
                         logic last);
    row_t r;
    r.b = b;
    r.known = known;
    r.want.lo = lo;
    r.want.hi = hi;
    r.want.last = last;
    rows.push_back(r);
  endtask

  initial begin
    logic [7:0] sc;
    int sel;
    bit held;
    held = 0;
    // Scale 127: code 2 is 1.0, code 0xF is -6, codes 0 and 8 give +0.
    add_row(8'd127, 0, 0, 0, 0);
    add_row(8'h20, 1, 16'h0000, 16'h3F80, 0);
    add_row(8'h8F, 1, 16'hC0C0, 16'h0000, 0);
    add_row(8'h71, 1, 16'h3F00, 16'h40C0, 0);
    add_row(8'h53, 1, 16'h3FC0, 16'h4040, 0);
    add_row(8'hC4, 1, 16'h4000, 16'hC000, 0);
    add_row(8'hE9, 1, 16'hBF00, 16'hC080, 0);
    for (int i = 0; i < 9; i++) add_row(8'($urandom), 0, 0, 0, 0);
    add_row(8'hFF, 1, 16'hC0C0, 16'hC0C0, 1);
    // Scale 255 gives signed zeros; all data bits toggled.
    add_row(8'd255, 0, 0, 0, 0);
    add_row(8'h9F, 1, 16'h8000, 16'h8000, 0);
    add_row(8'h71, 1, 16'h0000, 16'h0000, 0);
    add_row(8'h00, 1, 16'h0000, 16'h0000, 0);
    for (int i = 0; i < 13; i++) add_row(8'($urandom), 0, 0, 0, 0);
    // Scale 254 overflows, scale 1 flushes the half.
    add_row(8'd254, 0, 0, 0, 0);
    add_row(8'hE4, 1, 16'h7F80, 16'hFF80, 0);
    for (int i = 0; i < DATA_BYTES - 1; i++) add_row(8'($urandom), 0, 0, 0, 0);
    add_row(8'd1, 0, 0, 0, 0);
    add_row(8'h91, 1, 16'h0000, 16'h8000, 0);
    for (int i = 0; i < DATA_BYTES - 1; i++) add_row(8'($urandom), 0, 0, 0, 0);
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    foreach (rows[i]) send_byte(rows[i].b, rows[i].known, rows[i].want);
    while (r_total < N_RANDOM) begin
      quiet = (r_total > 400 && r_total < 700);
      if (!held && r_total >= 900) begin
        held = 1;
        hold_off = 1;
        fork
          begin
            repeat (60) @(posedge clk);
            hold_off = 0;
          end
        join_none
      end
      sel = $urandom_range(0, 9);
      case (sel)
        0: sc = 8'd0;
        1: sc = 8'd255;
        2: sc = 8'd1;
        3: sc = 8'($urandom_range(250, 254));
        default: sc = 8'($urandom);
      endcase
      send_block(sc);
      r_total += 1 + DATA_BYTES;
    end
    s_axis_tvalid <= 0;
    quiet = 0;
    while (pending_pairs.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end
endmodule
